[rtl/bcpb_pkg.sv]
// shared types and codes for the probability table blend
package bcpb_pkg;

   localparam int PCT_W = 8;
   localparam int PC_W = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;

   typedef logic [PCT_W-1:0] pct_type;
   typedef logic [PC_W-1:0] pcount_type;

   localparam logic [CSR_IDX_W-1:0] CSR_PARENT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CPT_LOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CPT_HIGH = 2'd2;

   localparam pcount_type PC_TWO = 3'd2;
   localparam pcount_type PC_THREE = 3'd3;

endpackage

[rtl/bcpb_cdiv.sv]
// pipelined divide by a constant with round-down, correction and saturation
module bcpb_cdiv #(
   parameter int LANES = 4,
   parameter int X_W = 24,
   parameter int DIVISOR = 10000,
   parameter int SAT = 100,
   parameter int SIDE_W = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [LANES-1:0][X_W-1:0] in_x,
   input  logic [SIDE_W-1:0] in_side,
   output logic out_valid,
   input  logic out_ready,
   output bcpb_pkg::pct_type [LANES-1:0] out_q,
   output logic [SIDE_W-1:0] out_side
);
   import bcpb_pkg::*;

   // floor reciprocal, estimate is low by at most one since x < 2^X_W
   localparam int R_W = X_W + 1;
   localparam int D_W = $clog2(DIVISOR + 1);
   localparam logic [R_W-1:0] RECIP = R_W'((64'd1 << X_W) / DIVISOR);
   localparam logic [D_W-1:0] DIV_C = D_W'(DIVISOR);
   localparam logic [X_W-1:0] DIV_X = X_W'(DIVISOR);
   localparam logic [X_W-1:0] SAT_X = X_W'(SAT);

   logic [2:0] v_ff;
   logic en0, en1, en2;

   logic [LANES-1:0][X_W-1:0] x1_ff, x2_ff;
   logic [LANES-1:0][X_W-1:0] qe1_ff, qe2_ff;
   logic [LANES-1:0][X_W-1:0] bp2_ff;
   pct_type [LANES-1:0] q3_ff;
   logic [SIDE_W-1:0] side1_ff, side2_ff, side3_ff;

   logic [LANES-1:0][X_W-1:0] qe1_in;
   logic [LANES-1:0][X_W-1:0] bp2_in;
   pct_type [LANES-1:0] q3_in;

   assign en2 = !v_ff[2] || out_ready;
   assign en1 = !v_ff[1] || en2;
   assign en0 = !v_ff[0] || en1;
   assign in_ready = en0;

   always_comb begin
      logic [X_W+R_W-1:0] prod;
      logic [X_W+D_W-1:0] back;
      logic [X_W-1:0] rem;
      logic [X_W-1:0] q;
      for (int i = 0; i < LANES; i++) begin
         prod = (X_W+R_W)'(in_x[i]) * (X_W+R_W)'(RECIP);
         qe1_in[i] = prod[X_W +: X_W];
         back = (X_W+D_W)'(qe1_ff[i]) * (X_W+D_W)'(DIV_C);
         bp2_in[i] = back[X_W-1:0];
         rem = x2_ff[i] - bp2_ff[i];
         q = (rem >= DIV_X) ? qe2_ff[i] + X_W'(1) : qe2_ff[i];
         q3_in[i] = (q > SAT_X) ? PCT_W'(SAT) : PCT_W'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en0) v_ff[0] <= in_valid;
         if (en1) v_ff[1] <= v_ff[0];
         if (en2) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         x1_ff <= in_x;
         qe1_ff <= qe1_in;
         side1_ff <= in_side;
      end
      if (en1) begin
         x2_ff <= x1_ff;
         qe2_ff <= qe1_ff;
         bp2_ff <= bp2_in;
         side2_ff <= side1_ff;
      end
      if (en2) begin
         q3_ff <= q3_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v_ff[2];
   assign out_q = q3_ff;
   assign out_side = side3_ff;

endmodule

[rtl/bayes_cpt_probability_blend.sv]
// probability table blend over up to four parents, pipelined top level
// throughput: one beat per cycle while rsp_ready is high; three constant dividers
// of three stages each set most of the depth; clamp, products and sums fill the rest
// reset: synchronous, clears all stage valid bits and the csr registers
// (parent_count to two, table to zero)
module bayes_cpt_probability_blend #(
   parameter int PCT_MAX = 100
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  bcpb_pkg::pct_type req_prob_a,
   input  bcpb_pkg::pct_type req_prob_b,
   input  bcpb_pkg::pct_type req_prob_c,
   input  bcpb_pkg::pct_type req_prob_d,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [6:0] rsp_prob_out,
   input  logic csr_we,
   input  logic [bcpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcpb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bcpb_pkg::*;

   localparam int SQ = PCT_MAX * PCT_MAX;
   localparam int XA_W = $clog2(SQ * 255 + SQ / 2 + 1);
   localparam int XB_W = $clog2(SQ + PCT_MAX / 2 + 1);
   localparam pct_type PCT = PCT_W'(PCT_MAX);
   localparam logic [25:0] BIAS_A = 26'(SQ / 2);
   localparam logic [16:0] BIAS_B = 17'(PCT_MAX / 2);

   // csr registers
   pcount_type pc_ff;
   logic [63:0] cpt_lo_ff, cpt_hi_ff;
   logic [127:0] cpt;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_TWO;
         cpt_lo_ff <= '0;
         cpt_hi_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PARENT_COUNT: pc_ff <= csr_wdata[PC_W-1:0];
            CSR_CPT_LOW:      cpt_lo_ff <= csr_wdata;
            CSR_CPT_HIGH:     cpt_hi_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   assign cpt = {cpt_hi_ff, cpt_lo_ff};

   // front stage valids and enables
   logic [3:0] vf_ff;
   logic [3:0] enf;
   logic diva_in_ready, diva_out_valid;
   logic divb_in_ready, divb_out_valid;
   logic divc_in_ready, divc_out_valid;
   logic [1:0] vm_ff, vn_ff;
   logic enm1, enm2, enn1, enn2;

   assign enf[3] = !vf_ff[3] || diva_in_ready;
   assign enf[2] = !vf_ff[2] || enf[3];
   assign enf[1] = !vf_ff[1] || enf[2];
   assign enf[0] = !vf_ff[0] || enf[1];
   assign req_ready = enf[0];

   // stage f1: clamp and complements
   pct_type a1_ff, b1_ff, c1_ff, d1_ff;
   pct_type na1_ff, nb1_ff, nc1_ff, nd1_ff;
   pct_type a_in, b_in, c_in, d_in;

   assign a_in = (req_prob_a > PCT) ? PCT : req_prob_a;
   assign b_in = (req_prob_b > PCT) ? PCT : req_prob_b;
   assign c_in = (req_prob_c > PCT) ? PCT : req_prob_c;
   assign d_in = (req_prob_d > PCT) ? PCT : req_prob_d;

   // stage f2: pair weights, order matches table entries base..base+3
   logic [3:0][15:0] w2_ff, w2_in;
   logic [31:0] side2_ff, side3_ff, side4_ff;

   assign w2_in[0] = 16'(na1_ff) * 16'(nb1_ff);
   assign w2_in[1] = 16'(a1_ff) * 16'(nb1_ff);
   assign w2_in[2] = 16'(na1_ff) * 16'(b1_ff);
   assign w2_in[3] = 16'(a1_ff) * 16'(b1_ff);

   // stage f3: weight times table entry, four groups of four
   logic [3:0][3:0][23:0] p3_ff, p3_in;
   // stage f4: group sums with rounding bias
   logic [3:0][XA_W-1:0] x4_ff, x4_in;

   always_comb begin
      logic [25:0] s;
      for (int k = 0; k < 4; k++) begin
         for (int j = 0; j < 4; j++) begin
            p3_in[k][j] = 24'(w2_ff[j]) * 24'(cpt[(4 * k + j) * 8 +: 8]);
         end
         s = 26'(p3_ff[k][0]) + 26'(p3_ff[k][1]) + 26'(p3_ff[k][2])
             + 26'(p3_ff[k][3]) + BIAS_A;
         x4_in[k] = s[XA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= '0;
      end else begin
         if (enf[0]) vf_ff[0] <= req_valid;
         if (enf[1]) vf_ff[1] <= vf_ff[0];
         if (enf[2]) vf_ff[2] <= vf_ff[1];
         if (enf[3]) vf_ff[3] <= vf_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (enf[0]) begin
         a1_ff <= a_in;
         b1_ff <= b_in;
         c1_ff <= c_in;
         d1_ff <= d_in;
         na1_ff <= PCT - a_in;
         nb1_ff <= PCT - b_in;
         nc1_ff <= PCT - c_in;
         nd1_ff <= PCT - d_in;
      end
      if (enf[1]) begin
         w2_ff <= w2_in;
         side2_ff <= {c1_ff, nc1_ff, d1_ff, nd1_ff};
      end
      if (enf[2]) begin
         p3_ff <= p3_in;
         side3_ff <= side2_ff;
      end
      if (enf[3]) begin
         x4_ff <= x4_in;
         side4_ff <= side3_ff;
      end
   end

   // two-parent results, divide by max squared
   pct_type [3:0] b2;
   logic [31:0] sidea;

   bcpb_cdiv #(
      .LANES(4), .X_W(XA_W), .DIVISOR(SQ), .SAT(PCT_MAX), .SIDE_W(32)
   ) u_diva (
      .clock(clock), .reset(reset),
      .in_valid(vf_ff[3]), .in_ready(diva_in_ready),
      .in_x(x4_ff), .in_side(side4_ff),
      .out_valid(diva_out_valid), .out_ready(enm1),
      .out_q(b2), .out_side(sidea)
   );

   // third parent blend: lo weighted by complement of c, hi by c
   pct_type c_a, nc_a;
   logic [3:0][15:0] pm1_ff, pm1_in;
   logic [1:0][XB_W-1:0] xm2_ff, xm2_in;
   logic [23:0] sm1_ff, sm2_ff;

   assign c_a = sidea[31:24];
   assign nc_a = sidea[23:16];
   assign enm2 = !vm_ff[1] || divb_in_ready;
   assign enm1 = !vm_ff[0] || enm2;

   always_comb begin
      logic [16:0] s;
      for (int k = 0; k < 2; k++) begin
         pm1_in[2 * k] = 16'(b2[2 * k]) * 16'(nc_a);
         pm1_in[2 * k + 1] = 16'(b2[2 * k + 1]) * 16'(c_a);
         s = 17'(pm1_ff[2 * k]) + 17'(pm1_ff[2 * k + 1]) + BIAS_B;
         xm2_in[k] = s[XB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= '0;
      end else begin
         if (enm1) vm_ff[0] <= diva_out_valid;
         if (enm2) vm_ff[1] <= vm_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (enm1) begin
         pm1_ff <= pm1_in;
         sm1_ff <= {sidea[15:0], b2[0]};
      end
      if (enm2) begin
         xm2_ff <= xm2_in;
         sm2_ff <= sm1_ff;
      end
   end

   pct_type [1:0] b3;
   logic [23:0] sideb;

   bcpb_cdiv #(
      .LANES(2), .X_W(XB_W), .DIVISOR(PCT_MAX), .SAT(PCT_MAX), .SIDE_W(24)
   ) u_divb (
      .clock(clock), .reset(reset),
      .in_valid(vm_ff[1]), .in_ready(divb_in_ready),
      .in_x(xm2_ff), .in_side(sm2_ff),
      .out_valid(divb_out_valid), .out_ready(enn1),
      .out_q(b3), .out_side(sideb)
   );

   // fourth parent blend
   pct_type d_b, nd_b;
   logic [1:0][15:0] pn1_ff, pn1_in;
   logic [0:0][XB_W-1:0] xn2_ff, xn2_in;
   logic [15:0] sn1_ff, sn2_ff;

   assign d_b = sideb[23:16];
   assign nd_b = sideb[15:8];
   assign enn2 = !vn_ff[1] || divc_in_ready;
   assign enn1 = !vn_ff[0] || enn2;

   assign pn1_in[0] = 16'(b3[0]) * 16'(nd_b);
   assign pn1_in[1] = 16'(b3[1]) * 16'(d_b);

   always_comb begin
      logic [16:0] s;
      s = 17'(pn1_ff[0]) + 17'(pn1_ff[1]) + BIAS_B;
      xn2_in[0] = s[XB_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= '0;
      end else begin
         if (enn1) vn_ff[0] <= divb_out_valid;
         if (enn2) vn_ff[1] <= vn_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (enn1) begin
         pn1_ff <= pn1_in;
         sn1_ff <= {sideb[7:0], b3[0]};
      end
      if (enn2) begin
         xn2_ff <= xn2_in;
         sn2_ff <= sn1_ff;
      end
   end

   pct_type [0:0] b4;
   logic [15:0] sidec;

   bcpb_cdiv #(
      .LANES(1), .X_W(XB_W), .DIVISOR(PCT_MAX), .SAT(PCT_MAX), .SIDE_W(16)
   ) u_divc (
      .clock(clock), .reset(reset),
      .in_valid(vn_ff[1]), .in_ready(divc_in_ready),
      .in_x(xn2_ff), .in_side(sn2_ff),
      .out_valid(divc_out_valid), .out_ready(rsp_ready),
      .out_q(b4), .out_side(sidec)
   );

   // side carries the two- and three-parent results of the same beat
   pct_type result;

   always_comb begin
      if (pc_ff <= PC_TWO) begin
         result = sidec[15:8];
      end else if (pc_ff == PC_THREE) begin
         result = sidec[7:0];
      end else begin
         result = b4[0];
      end
   end

   assign rsp_valid = divc_out_valid;
   assign rsp_prob_out = result[6:0];

   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> result <= PCT)
      else $error("blended result above maximum");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vf_ff[0])
      else $error("accepted beat did not enter first stage");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !vf_ff[0] && !vm_ff[0] && !vn_ff[0])
      else $error("pipeline not empty after reset");

endmodule

[test/bayes_cpt_probability_blend_checker.sv]
// checker for the probability table blend: predicts each rsp beat and compares it
`timescale 1ns / 100ps

module bayes_cpt_probability_blend_checker #(
   parameter int PCT_MAX = 100
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  bcpb_pkg::pct_type req_prob_a,
   input  bcpb_pkg::pct_type req_prob_b,
   input  bcpb_pkg::pct_type req_prob_c,
   input  bcpb_pkg::pct_type req_prob_d,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [6:0] rsp_prob_out,
   input  logic csr_we,
   input  logic [bcpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcpb_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int fail_count,
   output int pending
);
   import bcpb_pkg::*;

   localparam int unsigned M = PCT_MAX;

   pcount_type parent_count;
   logic [CSR_DATA_W-1:0] cpt_low;
   logic [CSR_DATA_W-1:0] cpt_high;
   logic [6:0] blend_expected_q[$];

   task automatic report_mismatch(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic int unsigned clamp_pct(pct_type p);
      return (p > M) ? M : int'(p);
   endfunction

   function automatic int unsigned cpt_byte(int unsigned idx);
      logic [CSR_DATA_W-1:0] word;
      word = idx[3] ? cpt_high : cpt_low;
      return int'(word[idx[2:0]*8 +: 8]);
   endfunction

   // two parents over four entries, scaled back by max squared
   function automatic int unsigned mix_pair(int unsigned a, int unsigned b,
                                            int unsigned base);
      int unsigned acc;
      int unsigned sq;
      sq = M * M;
      acc = (M - a) * (M - b) * cpt_byte(base);
      acc += a * (M - b) * cpt_byte(base + 1);
      acc += (M - a) * b * cpt_byte(base + 2);
      acc += a * b * cpt_byte(base + 3);
      acc = (acc + sq / 2) / sq;
      return (acc > M) ? M : acc;
   endfunction

   function automatic int unsigned mix_stage(int unsigned lo, int unsigned hi,
                                             int unsigned w);
      int unsigned acc;
      acc = lo * (M - w) + hi * w;
      acc = (acc + M / 2) / M;
      return (acc > M) ? M : acc;
   endfunction

   function automatic int unsigned mix_triple(int unsigned a, int unsigned b,
                                              int unsigned c, int unsigned base);
      return mix_stage(mix_pair(a, b, base), mix_pair(a, b, base + 4), c);
   endfunction

   function automatic logic [6:0] predict_blend(pct_type pa, pct_type pb,
                                                pct_type pc, pct_type pd);
      int unsigned a;
      int unsigned b;
      int unsigned c;
      int unsigned d;
      int unsigned r;
      a = clamp_pct(pa);
      b = clamp_pct(pb);
      c = clamp_pct(pc);
      d = clamp_pct(pd);
      // counts below two act as two, above four as four
      if (parent_count <= PC_TWO) begin
         r = mix_pair(a, b, 0);
      end else if (parent_count == PC_THREE) begin
         r = mix_triple(a, b, c, 0);
      end else begin
         r = mix_stage(mix_triple(a, b, c, 0), mix_triple(a, b, c, 8), d);
      end
      return r[6:0];
   endfunction

   always @(posedge clock) begin
      logic [6:0] want;
      if (reset) begin
         parent_count = PC_TWO;
         cpt_low = '0;
         cpt_high = '0;
         blend_expected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (blend_expected_q.size() == 0) begin
               report_mismatch($sformatf("rsp beat %0d with nothing pending", rsp_prob_out));
            end else begin
               want = blend_expected_q.pop_front();
               if (rsp_prob_out !== want) begin
                  report_mismatch($sformatf("prob_out got %0d want %0d", rsp_prob_out, want));
               end
            end
         end
         // predict with the settings in force before any write on this edge
         if (req_valid && req_ready) begin
            blend_expected_q.push_back(predict_blend(req_prob_a, req_prob_b,
                                                     req_prob_c, req_prob_d));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PARENT_COUNT: parent_count = csr_wdata[PC_W-1:0];
               CSR_CPT_LOW: cpt_low = csr_wdata;
               CSR_CPT_HIGH: cpt_high = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = blend_expected_q.size();
   end

endmodule

[test/bayes_cpt_probability_blend_test.sv]
// top of the probability table blend testbench: stimulus, settings and verdict
`timescale 1ns / 100ps

module bayes_cpt_probability_blend_test;
   import bcpb_pkg::*;

   localparam int PCT_MAX = 100;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_BEATS = 100;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam pcount_type PC_ZERO = 3'd0;
   localparam pcount_type PC_ONE = 3'd1;
   localparam pcount_type PC_FOUR = 3'd4;
   localparam pcount_type PC_FIVE = 3'd5;
   localparam pcount_type PC_SEVEN = 3'd7;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   pct_type req_prob_a;
   pct_type req_prob_b;
   pct_type req_prob_c;
   pct_type req_prob_d;
   logic rsp_valid;
   logic rsp_ready;
   logic [6:0] rsp_prob_out;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int idle_pct;
   int sent_count;
   int setting_count;
   int cycle_count;

   always #1 clock = ~clock;

   bayes_cpt_probability_blend #(.PCT_MAX(PCT_MAX)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_prob_a(req_prob_a),
      .req_prob_b(req_prob_b),
      .req_prob_c(req_prob_c),
      .req_prob_d(req_prob_d),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_prob_out(rsp_prob_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   bayes_cpt_probability_blend_checker #(.PCT_MAX(PCT_MAX)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_prob_a(req_prob_a),
      .req_prob_b(req_prob_b),
      .req_prob_c(req_prob_c),
      .req_prob_d(req_prob_d),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_prob_out(rsp_prob_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   // receiver stalls in bursts and is released between them
   always begin
      @(negedge clock);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      rsp_ready <= 1'b1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("bayes_cpt_probability_blend_test NOT OK");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic push_request(pct_type a, pct_type b, pct_type c, pct_type d);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_prob_a <= a;
      req_prob_b <= b;
      req_prob_c <= c;
      req_prob_d <= d;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setting(pcount_type count, logic [63:0] lo, logic [63:0] hi);
      write_csr(CSR_PARENT_COUNT, CSR_DATA_W'(count));
      write_csr(CSR_CPT_LOW, lo);
      write_csr(CSR_CPT_HIGH, hi);
      setting_count++;
   endtask

   // block idle: nothing in flight before touching the registers
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic pct_type rand_pct();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd100;
         2: return 8'd255;
         3: return pct_type'($urandom_range(101, 255));
         default: return pct_type'($urandom_range(0, 100));
      endcase
   endfunction

   function automatic logic [63:0] rand_cpt_word();
      logic [63:0] word;
      word = '0;
      case ($urandom_range(0, 5))
         0: word = '0;
         1: word = '1;
         2: word = {$urandom(), $urandom()};
         default: begin
            for (int i = 0; i < 8; i++) word[i*8 +: 8] = 8'($urandom_range(0, 100));
         end
      endcase
      return word;
   endfunction

   initial begin
      pcount_type count;
      reset = 1'b1;
      req_valid = 1'b0;
      req_prob_a = '0;
      req_prob_b = '0;
      req_prob_c = '0;
      req_prob_d = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_pct = 0;
      sent_count = 0;
      setting_count = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: two parents, all-zero table
      idle_pct = 10;
      push_request(8'd0, 8'd0, 8'd0, 8'd0);
      push_request(8'd255, 8'd255, 8'd255, 8'd255);
      drain_results();

      // saturated table, clamping of parents above max
      apply_setting(PC_TWO, '1, '1);
      push_request(8'd100, 8'd100, 8'd0, 8'd0);
      push_request(8'd101, 8'd0, 8'd0, 8'd0);
      push_request(8'd255, 8'd50, 8'd0, 8'd0);
      push_request(8'd50, 8'd50, 8'd0, 8'd0);
      drain_results();

      // four parents, mixed table entries; corners pick single entries
      apply_setting(PC_FOUR, 64'h6400_3F12_5507_C801, 64'h0980_6433_00FF_2A5E);
      push_request(8'd0, 8'd0, 8'd0, 8'd0);
      push_request(8'd100, 8'd100, 8'd100, 8'd100);
      push_request(8'd255, 8'd255, 8'd255, 8'd255);
      push_request(8'd100, 8'd0, 8'd0, 8'd0);
      push_request(8'd0, 8'd100, 8'd0, 8'd0);
      push_request(8'd0, 8'd0, 8'd100, 8'd0);
      push_request(8'd0, 8'd0, 8'd0, 8'd100);
      push_request(8'd50, 8'd50, 8'd50, 8'd50);
      push_request(8'd1, 8'd99, 8'd37, 8'd63);
      drain_results();

      // three parents: fourth must be ignored
      write_csr(CSR_PARENT_COUNT, CSR_DATA_W'(PC_THREE));
      push_request(8'd40, 8'd70, 8'd90, 8'd0);
      push_request(8'd40, 8'd70, 8'd90, 8'd255);
      drain_results();

      // unused index, then out-of-range parent counts
      write_csr(CSR_UNUSED, '1);
      write_csr(CSR_PARENT_COUNT, CSR_DATA_W'(PC_ZERO));
      push_request(8'd30, 8'd60, 8'd200, 8'd200);
      drain_results();
      write_csr(CSR_PARENT_COUNT, CSR_DATA_W'(PC_ONE));
      push_request(8'd30, 8'd60, 8'd200, 8'd200);
      drain_results();
      write_csr(CSR_PARENT_COUNT, CSR_DATA_W'(PC_FIVE));
      push_request(8'd30, 8'd60, 8'd80, 8'd20);
      drain_results();
      write_csr(CSR_PARENT_COUNT, CSR_DATA_W'(PC_SEVEN));
      push_request(8'd30, 8'd60, 8'd80, 8'd20);
      drain_results();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         // every count value once, then mostly the legal ones
         if (p < 8) begin
            count = pcount_type'(p);
         end else if ($urandom_range(0, 9) < 8) begin
            count = pcount_type'($urandom_range(2, 4));
         end else begin
            count = pcount_type'($urandom_range(0, 7));
         end
         apply_setting(count, rand_cpt_word(), rand_cpt_word());
         if (p >= RANDOM_PHASES - 2) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: idle_pct = 0;
               1: idle_pct = 5;
               2: idle_pct = 20;
               default: idle_pct = 50;
            endcase
         end
         for (int n = 0; n < PHASE_BEATS; n++) begin
            push_request(rand_pct(), rand_pct(), rand_pct(), rand_pct());
         end
         drain_results();
      end

      repeat (40) @(negedge clock);
      $display("covered %0d request beats over %0d register settings", sent_count,
               setting_count);
      $display("parent counts 0 to 7, clamped parents and saturating tables included");
      if (fail_count == 0 && pending == 0) begin
         $display("bayes_cpt_probability_blend_test OK");
      end else begin
         $display("bayes_cpt_probability_blend_test NOT OK");
      end
      $finish;
   end

endmodule
